[src/rtd_ratio_to_temperature_defines.svh]
// Assertion macros for the RTD conversion checker.
// No dependencies.
`ifndef RTD_RATIO_TO_TEMPERATURE_DEFINES_SVH
`define RTD_RATIO_TO_TEMPERATURE_DEFINES_SVH

// Same-cycle implication under active-low reset.
`define RTD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a fixed delay in cycles.
`define RTD_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

[src/rtd_pkg.sv]
// Constants and types for the RTD ratio to temperature pipeline.
// No dependencies.
`default_nettype none
package rtd_pkg;

    typedef enum logic {
        CFG_REF_RES = 1'b0,
        CFG_NOM_RES = 1'b1
    } t_cfg_idx;

    localparam int REG_W    = 20;
    localparam int DIV_BITS = 27;
    localparam int SQ_STEPS = 32;
    // prod, dividend, divider, multiply, sum, clamp, root, scale, abs, recip, out
    localparam int LAT = 1 + 1 + DIV_BITS + 1 + 1 + 1 + SQ_STEPS + 1 + 1 + 1 + 1;

    localparam logic [19:0] REF_RES_RST = 20'd43000;
    localparam logic [19:0] NOM_RES_RST = 20'd10000;

    localparam logic [63:0] P5_14   = 64'd6103515625;
    localparam logic [63:0] K1_HI   = (64'd1758480889 << 20) / P5_14;
    localparam logic [63:0] K1_LO   = (((64'd1758480889 << 20) % P5_14) << 20) / P5_14;
    localparam logic [63:0] K1_FULL = (K1_HI << 20) + K1_LO;
    localparam logic [63:0] K2_FULL = (64'd231 << 46) / 64'd390625;
    localparam logic [63:0] AQ_FULL = (64'd39083 << 32) / 64'd78125;

    localparam logic [38:0] K1_C  = K1_FULL[38:0];
    localparam logic [17:0] K2_LO = K2_FULL[17:0];
    localparam logic [17:0] K2_HI = K2_FULL[35:18];
    localparam logic [31:0] AQ_C  = AQ_FULL[31:0];

    localparam logic signed [56:0] TEN_MUL = 57'sd3906250;
    localparam logic signed [56:0] TEN_DEN = 57'sd231 <<< 30;
    localparam logic signed [56:0] OOR_LO  = -(57'sd500 * TEN_DEN);
    localparam logic signed [56:0] OOR_HI  = 57'sd9000 * TEN_DEN;

    localparam logic [63:0] RECIP_FULL = (64'd1 << 32) / 64'd231;
    localparam logic [24:0] RECIP_231  = RECIP_FULL[24:0];
    localparam logic [26:0] DIV_231    = 27'd231;

endpackage
`default_nettype wire

[src/rtd_ratio_to_temperature.sv]
// RTD ratio to temperature conversion, fully pipelined top level.
// Depends on rtd_pkg.
//
// Usage:
//   Input channel: drive i_rtd_word and raise i_start; the word is taken at
//   every rising edge where i_start is high and o_busy is low. o_busy stays
//   low, so one beat can enter every cycle.
//   Output channel: o_valid strobes for one cycle with o_temp_tenths,
//   o_ratio_code, o_rtd_fault and o_out_of_range. The receiver cannot stall;
//   each beat must be taken in the cycle it is shown.
//   Throughput: one beat per cycle, set by the 27-stage ratio divider and
//   the 32-stage square root, each retiring one bit per stage.
//   Configuration: write reference_resistance (index 0) or
//   nominal_resistance (index 1) through i_cfg_we only while the pipeline
//   is drained; the registers feed the pipe live.
//   Reset: synchronous, active low; clears the valid line and loads the
//   register defaults. Payload registers are not reset.
`default_nettype none
module rtd_ratio_to_temperature
    import rtd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [15:0]        i_rtd_word,
    output      logic               o_busy,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [19:0]        i_cfg_data,
    output      logic               o_valid,
    output      logic signed [16:0] o_temp_tenths,
    output      logic [14:0]        o_ratio_code,
    output      logic               o_rtd_fault,
    output      logic               o_out_of_range
);

    // Configuration registers.
    logic [19:0] r_ref_res;
    logic [19:0] r_nom_res;
    logic [19:0] w_r0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_res <= REF_RES_RST;
            r_nom_res <= NOM_RES_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_REF_RES: r_ref_res <= i_cfg_data;
                CFG_NOM_RES: r_nom_res <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Zero nominal resistance divides by one.
    assign w_r0   = (r_nom_res == '0) ? 20'd1 : r_nom_res;
    assign o_busy = 1'b0;

    // Valid line and word side line; every stage advances each cycle.
    logic [LAT-1:0] r_vpipe;
    logic [15:0]    r_side [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe <= '0;
        end else begin
            r_vpipe <= {r_vpipe[LAT-2:0], i_start & ~o_busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_rtd_word;
        for (int i = 1; i < LAT; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // Stage: code times reference resistance.
    logic [34:0] r_prod;
    always_ff @(posedge i_clk) begin
        r_prod <= 35'(i_rtd_word[15:1]) * 35'(r_ref_res);
    end

    // Stage: split the scaled dividend; flag ratios of eight or more.
    logic [43:0] w_num44;
    logic [16:0] r_dv0_hi;
    logic [26:0] r_dv0_low;
    logic        r_dv0_sat;

    assign w_num44 = {r_prod, 9'b0};

    always_ff @(posedge i_clk) begin
        r_dv0_hi  <= w_num44[43:27];
        r_dv0_low <= w_num44[26:0];
        r_dv0_sat <= ({3'b0, w_num44[43:27]} >= w_r0);
    end

    // Restoring divider, one quotient bit per stage.
    logic [19:0] r_dv_rem [DIV_BITS];
    logic [26:0] r_dv_low [DIV_BITS];
    logic [26:0] r_dv_q   [DIV_BITS];
    logic        r_dv_sat [DIV_BITS];
    logic [19:0] n_dv_rem [DIV_BITS];
    logic [26:0] n_dv_low [DIV_BITS];
    logic [26:0] n_dv_q   [DIV_BITS];
    logic        n_dv_sat [DIV_BITS];

    always_comb begin
        logic [19:0] in_rem;
        logic [26:0] in_low;
        logic [26:0] in_q;
        logic        in_sat;
        logic [20:0] t;
        for (int i = 0; i < DIV_BITS; i++) begin
            if (i == 0) begin
                in_rem = {3'b0, r_dv0_hi};
                in_low = r_dv0_low;
                in_q   = '0;
                in_sat = r_dv0_sat;
            end else begin
                in_rem = r_dv_rem[i-1];
                in_low = r_dv_low[i-1];
                in_q   = r_dv_q[i-1];
                in_sat = r_dv_sat[i-1];
            end
            t = {in_rem, in_low[26]};
            if (t >= {1'b0, w_r0}) begin
                n_dv_rem[i] = 20'(t - {1'b0, w_r0});
                n_dv_q[i]   = {in_q[25:0], 1'b1};
            end else begin
                n_dv_rem[i] = t[19:0];
                n_dv_q[i]   = {in_q[25:0], 1'b0};
            end
            n_dv_low[i] = {in_low[25:0], 1'b0};
            n_dv_sat[i] = in_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_rem <= n_dv_rem;
        r_dv_low <= n_dv_low;
        r_dv_q   <= n_dv_q;
        r_dv_sat <= n_dv_sat;
    end

    // Stage: K2 times q as two partial products.
    logic [44:0] r_p_lo;
    logic [44:0] r_p_hi;
    logic        r_p_sat;
    always_ff @(posedge i_clk) begin
        r_p_lo  <= 45'(r_dv_q[DIV_BITS-1]) * 45'(K2_LO);
        r_p_hi  <= 45'(r_dv_q[DIV_BITS-1]) * 45'(K2_HI);
        r_p_sat <= r_dv_sat[DIV_BITS-1];
    end

    // Stage: sum the partial products and drop 24 fraction bits.
    logic [62:0] w_psum;
    logic [38:0] r_m;
    logic        r_m_sat;
    assign w_psum = {r_p_hi, 18'b0} + {18'b0, r_p_lo};
    always_ff @(posedge i_clk) begin
        r_m     <= w_psum[62:24];
        r_m_sat <= r_p_sat;
    end

    // Stage: root argument, clamped at zero.
    logic [38:0] r_d;
    always_ff @(posedge i_clk) begin
        r_d <= (!r_m_sat && (K1_C > r_m)) ? 39'(K1_C - r_m) : '0;
    end

    // Digit-by-digit square root of {D, 24 zero bits}, one root bit per stage.
    logic [33:0] r_sq_rem  [SQ_STEPS];
    logic [31:0] r_sq_root [SQ_STEPS];
    logic [38:0] r_sq_d    [SQ_STEPS];
    logic [33:0] n_sq_rem  [SQ_STEPS];
    logic [31:0] n_sq_root [SQ_STEPS];
    logic [38:0] n_sq_d    [SQ_STEPS];

    always_comb begin
        logic [33:0] in_rem;
        logic [31:0] in_root;
        logic [38:0] in_d;
        logic [63:0] arg;
        logic [35:0] trem;
        logic [35:0] trial;
        for (int j = 0; j < SQ_STEPS; j++) begin
            if (j == 0) begin
                in_rem  = '0;
                in_root = '0;
                in_d    = r_d;
            end else begin
                in_rem  = r_sq_rem[j-1];
                in_root = r_sq_root[j-1];
                in_d    = r_sq_d[j-1];
            end
            arg   = {1'b0, in_d, 24'b0};
            trem  = {in_rem, arg[63-2*j -: 2]};
            trial = {2'b0, in_root, 2'b01};
            if (trem >= trial) begin
                n_sq_rem[j]  = 34'(trem - trial);
                n_sq_root[j] = {in_root[30:0], 1'b1};
            end else begin
                n_sq_rem[j]  = trem[33:0];
                n_sq_root[j] = {in_root[30:0], 1'b0};
            end
            n_sq_d[j] = in_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_rem  <= n_sq_rem;
        r_sq_root <= n_sq_root;
        r_sq_d    <= n_sq_d;
    end

    // Stage: scaled numerator (A - sqrt) times 3906250.
    logic signed [33:0] w_diff;
    logic signed [56:0] r_num;
    assign w_diff = $signed({2'b0, AQ_C}) - $signed({2'b0, r_sq_root[SQ_STEPS-1]});
    always_ff @(posedge i_clk) begin
        r_num <= 57'(w_diff) * TEN_MUL;
    end

    // Stage: magnitude over 2^30, sign and range flag.
    logic [56:0] w_abs;
    logic [26:0] r_a;
    logic        r_a_neg;
    logic        r_a_oor;
    assign w_abs = r_num[56] ? 57'(-r_num) : 57'(r_num);
    always_ff @(posedge i_clk) begin
        r_a     <= w_abs[56:30];
        r_a_neg <= r_num[56];
        r_a_oor <= (r_num < OOR_LO) || (r_num > OOR_HI);
    end

    // Stage: quotient estimate by 231 through the reciprocal.
    logic [51:0] w_rprod;
    logic [19:0] r_qe;
    logic [26:0] r_qa;
    logic        r_q_neg;
    logic        r_q_oor;
    assign w_rprod = 52'(r_a) * 52'(RECIP_231);
    always_ff @(posedge i_clk) begin
        r_qe    <= w_rprod[51:32];
        r_qa    <= r_a;
        r_q_neg <= r_a_neg;
        r_q_oor <= r_a_oor;
    end

    // Stage: one correction step, restore sign, hold the result.
    logic [26:0] w_rem;
    logic [19:0] w_qf;
    logic signed [16:0] r_temp;
    logic               r_oor;
    assign w_rem = r_qa - 27'(27'(r_qe) * DIV_231);
    assign w_qf  = r_qe + ((w_rem >= DIV_231) ? 20'd1 : 20'd0);
    always_ff @(posedge i_clk) begin
        r_temp <= r_q_neg ? $signed(17'(-w_qf)) : $signed(17'(w_qf));
        r_oor  <= r_q_oor;
    end

    assign o_valid        = r_vpipe[LAT-1];
    assign o_temp_tenths  = r_temp;
    assign o_ratio_code   = r_side[LAT-1][15:1];
    assign o_rtd_fault    = r_side[LAT-1][0];
    assign o_out_of_range = r_oor;

endmodule
`default_nettype wire

[src/rtd_chk.sv]
// Port-level checker for the RTD conversion pipeline, bound to the top level.
// Depends on rtd_pkg and rtd_ratio_to_temperature_defines.svh.
`default_nettype none
`include "rtd_ratio_to_temperature_defines.svh"
module rtd_chk
    import rtd_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_start,
    input wire logic [15:0]        i_rtd_word,
    input wire logic               o_busy,
    input wire logic               o_valid,
    input wire logic [14:0]        o_ratio_code,
    input wire logic               o_rtd_fault
);

    `RTD_ASSERT_DELAY(a_beat_out, i_clk, i_rst_n, i_start && !o_busy, LAT, o_valid, "beat lost")
    `RTD_ASSERT_IMPLY(a_no_extra, i_clk, i_rst_n, o_valid, $past(i_start && !o_busy, LAT), "beat invented")
    `RTD_ASSERT_IMPLY(a_code, i_clk, i_rst_n, o_valid, o_ratio_code == $past(i_rtd_word[15:1], LAT), "code mismatch")
    `RTD_ASSERT_IMPLY(a_fault, i_clk, i_rst_n, o_valid, o_rtd_fault == $past(i_rtd_word[0], LAT), "fault mismatch")

endmodule

bind rtd_ratio_to_temperature rtd_chk u_rtd_chk (.*);
`default_nettype wire
